// ----- hdl/igse_pkg.sv -----
`default_nettype none

package igse_pkg;

  typedef logic signed [15:0] s16_t;

  localparam int unsigned X_END_Q16        = 524288;
  localparam longint      EXP_M1_Q30       = 64'd395007542;
  localparam int unsigned GYRO_TO_RATE_Q16 = 73204;
  localparam int unsigned X_DIV_DEN        = 1000000;
  localparam int unsigned X_DIV_HALF       = 500000;
  localparam int unsigned ALPHA_SCALE      = 62500;

  // x = floor((4 * rate * step + X_RND) / 15625), by reciprocal 2^47 / 15625;
  // exact for numerators below X_BIG, which is where x reaches 8.0
  localparam int unsigned     X_RND   = 7812;
  localparam longint unsigned X_RECIP = 64'd9007199255;
  localparam longint unsigned X_BIG   = 64'd8192000000;

  localparam logic [2:0] CFG_AXIS_MAP  = 3'd0;
  localparam logic [2:0] CFG_LP_RATE   = 3'd1;
  localparam logic [2:0] CFG_GRAV_SCL  = 3'd2;
  localparam logic [2:0] CFG_SHAKE_SCL = 3'd3;
  localparam logic [2:0] CFG_FF_THRESH = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_XSTART, ST_XWAIT, ST_COEF0, ST_COEF1, ST_COEF2,
    ST_UMUL, ST_UADD, ST_SQ, ST_SUM, ST_RSTART, ST_RWAIT, ST_DSTART,
    ST_DWAIT, ST_ASTART, ST_AWAIT, ST_FMUL, ST_FFIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic upd_mul;
    logic upd_add;
    logic primed;
    logic sq;
    logic dir_start;
    logic alpha_start;
    logic force_mul;
    logic force_fin;
    logic commit;
  } lane_cmd_t;

  // series term divided by its index; elaboration only
  function automatic longint unsigned div_term(longint unsigned t, int k);
    case (k)
      2:  return t / 2;
      3:  return t / 3;
      4:  return t / 4;
      5:  return t / 5;
      6:  return t / 6;
      7:  return t / 7;
      8:  return t / 8;
      9:  return t / 9;
      10: return t / 10;
      11: return t / 11;
      12: return t / 12;
      default: return t;
    endcase
  endfunction

  // exp(-x) in Q30 for x in Q16, x up to 8.0; elaboration only
  function automatic longint exp_neg_q30(longint unsigned x);
    longint unsigned n;
    longint unsigned f;
    longint unsigned term;
    longint          sum;
    int              k;
    int              j;
    n    = x >> 16;
    f    = x & 64'hFFFF;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (k = 1; k <= 12; k++) begin
      term = div_term((term * f) >> 16, k);
      sum  = k[0] ? sum - longint'(term) : sum + longint'(term);
    end
    for (j = 0; j < 8; j++) begin
      if (j < n) begin
        sum = (sum * EXP_M1_Q30 + (64'd1 << 29)) >>> 30;
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/igse_if.sv -----
`default_nettype none

interface igse_sample_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [19:0]        step_us;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  step_us, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                step_us, output ready);
endinterface

interface igse_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [16:0] rate_x;
  logic signed [16:0] rate_y;
  logic signed [16:0] rate_z;
  logic signed [31:0] spin_accel_x;
  logic signed [31:0] spin_accel_y;
  logic signed [31:0] spin_accel_z;
  logic               free_fall;

  modport source (output valid, force_x, force_y, force_z, rate_x, rate_y, rate_z,
                  spin_accel_x, spin_accel_y, spin_accel_z, free_fall, input ready);
  modport sink (input valid, force_x, force_y, force_z, rate_x, rate_y, rate_z,
                spin_accel_x, spin_accel_y, spin_accel_z, free_fall, output ready);
endinterface

`default_nettype wire

// ----- hdl/igse_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module igse_div #(
  parameter int NW = 40,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;

  assign trial = {rem, quot[NW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      quot <= {quot[NW-2:0], qbit};
      rem  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/igse_isqrt.sv -----
`default_nettype none

// integer square root, two radicand bits per cycle
module igse_isqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   num,
  output logic           done,
  output logic [W/2-1:0] root
);

  localparam int CW = $clog2(W / 2 + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  v;
  logic [W-1:0]  r;
  logic [W-1:0]  b;
  logic [W-1:0]  rb;

  assign rb   = r + b;
  assign root = r[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W / 2);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= num;
      r <= '0;
      b <= W'(1) << (W - 2);
    end else if (busy) begin
      if (v >= rb) begin
        v <= v - rb;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/igse_coef.sv -----
`default_nettype none

// k = 1 - exp(-x), table with linear interpolation, three register stages
module igse_coef #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic [44:0] x,
  output logic [16:0] k
);

  localparam int IW   = $clog2(DEPTH);
  localparam int NUMW = 19 + IW;

  logic [16:0] tab [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
    localparam longint unsigned XI =
      (longint'(gi) * igse_pkg::X_END_Q16 + (DEPTH - 1) / 2) / (DEPTH - 1);
    localparam longint TP = 65536 - ((igse_pkg::exp_neg_q30(XI) + 8192) >>> 14);
    assign tab[gi] = 17'(TP);
  end

  logic [NUMW-1:0]    num;
  logic               big1;
  logic [IW-1:0]      idx1;
  logic [18:0]        rem1;
  logic               big2;
  logic [16:0]        t0_2;
  logic signed [37:0] prod2;
  logic signed [17:0] tdiff;
  logic [IW-1:0]      idx1p;

  assign num   = NUMW'(x[18:0]) * NUMW'(DEPTH - 1);
  assign idx1p = idx1 + 1'b1;
  assign tdiff = $signed({1'b0, tab[idx1p]}) - $signed({1'b0, tab[idx1]});

  always_ff @(posedge clk) begin
    big1  <= |x[44:19];
    idx1  <= num[NUMW-1:19];
    rem1  <= num[18:0];
    big2  <= big1;
    t0_2  <= tab[idx1];
    prod2 <= 38'(tdiff) * 38'($signed({1'b0, rem1}));
    k     <= big2 ? 17'd65536 : 17'($signed({1'b0, t0_2}) + 18'(prod2 >>> 19));
  end

endmodule

`default_nettype wire

// ----- hdl/igse_lane.sv -----
`default_nettype none

module igse_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  igse_pkg::lane_cmd_t   cmd,
  input  logic [2:0]            map,
  input  igse_pkg::s16_t        accel_src [3],
  input  igse_pkg::s16_t        gyro_src [3],
  input  logic [16:0]           k,
  input  logic [23:0]           mag,
  input  logic                  fall,
  input  logic                  is_down,
  input  logic [19:0]           step,
  input  logic [23:0]           gravity_scale,
  input  logic [23:0]           shake_scale,
  output logic [47:0]           square,
  output logic signed [16:0]    rate,
  output logic signed [31:0]    frc,
  output logic signed [31:0]    alpha,
  output logic                  div_done
);

  function automatic logic [31:0] sat_sm(logic neg, logic [39:0] m);
    if (!neg) begin
      return (m > 40'h007FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    return (m > 40'h0080000000) ? 32'h80000000 : 32'(~m[31:0] + 32'd1);
  endfunction

  logic signed [16:0] a_pick, a_map, g_pick, g_map;
  logic [16:0]        g_abs;
  logic [33:0]        rate_prod;
  logic [33:0]        rate_rnd;
  logic signed [16:0] rate_new;

  logic signed [24:0] acc;
  logic signed [24:0] g;
  logic signed [16:0] prev;
  logic signed [43:0] uprod;
  logic signed [17:0] dir;
  logic signed [42:0] pd;
  logic signed [50:0] ps;
  logic               is_alpha;
  logic               dneg;

  logic signed [25:0] d;
  logic [23:0]        gm;
  logic signed [17:0] rdiff;
  logic [17:0]        rdiff_abs;
  logic [39:0]        dir_num;
  logic [39:0]        alpha_num;
  logic [39:0]        quot;
  logic signed [51:0] f;
  logic [51:0]        f_abs;
  logic [51:0]        f_rnd;

  always_comb begin
    case (map[1:0])
      2'd0: begin
        a_pick = 17'(accel_src[0]);
        g_pick = 17'(gyro_src[0]);
      end
      2'd1: begin
        a_pick = 17'(accel_src[1]);
        g_pick = 17'(gyro_src[1]);
      end
      2'd2: begin
        a_pick = 17'(accel_src[2]);
        g_pick = 17'(gyro_src[2]);
      end
      default: begin
        a_pick = '0;
        g_pick = '0;
      end
    endcase
  end

  assign a_map     = map[2] ? -a_pick : a_pick;
  assign g_map     = map[2] ? -g_pick : g_pick;
  assign g_abs     = g_map[16] ? 17'(-g_map) : 17'(g_map);
  assign rate_prod = 34'(g_abs) * 34'(igse_pkg::GYRO_TO_RATE_Q16);
  assign rate_rnd  = rate_prod + 34'd32768;
  assign rate_new  = g_map[16] ? -$signed(rate_rnd[32:16]) : $signed(rate_rnd[32:16]);

  assign d         = 26'(acc) - 26'(g);
  assign gm        = g[24] ? 24'(-g) : 24'(g);
  assign rdiff     = 18'(rate) - 18'(prev);
  assign rdiff_abs = rdiff[17] ? 18'(-rdiff) : 18'(rdiff);
  assign dir_num   = {gm, 16'd0} + 40'(mag >> 1);
  assign alpha_num = 40'(rdiff_abs) * 40'(igse_pkg::ALPHA_SCALE) + 40'(step >> 1);

  assign f     = 52'(pd) - 52'(ps);
  assign f_abs = f[51] ? 52'(-f) : 52'(f);
  assign f_rnd = (f_abs + 52'd32768) >> 16;

  igse_div #(.NW(40), .DW(24)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.dir_start | cmd.alpha_start),
    .num   (cmd.alpha_start ? alpha_num : dir_num),
    .den   (cmd.alpha_start ? {4'd0, step} : mag),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g        <= '0;
      prev     <= '0;
      is_alpha <= 1'b0;
    end else begin
      if (cmd.upd_add) begin
        g <= cmd.primed ? 25'(28'(g) + 28'((uprod + 44'sd32768) >>> 16)) : acc;
      end
      if (cmd.commit) begin
        prev <= rate;
      end
      if (cmd.dir_start | cmd.alpha_start) begin
        is_alpha <= cmd.alpha_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc  <= 25'(a_map) <<< 8;
      rate <= rate_new;
    end
    if (cmd.upd_mul) begin
      uprod <= 44'($signed({1'b0, k})) * 44'(d);
    end
    if (cmd.sq) begin
      square <= 48'(50'(g) * 50'(g));
    end
    if (cmd.dir_start | cmd.alpha_start) begin
      dneg <= rdiff[17];
    end
    if (div_done) begin
      if (is_alpha) begin
        alpha <= (step < 20'd2) ? 32'sd0 : $signed(sat_sm(dneg, quot));
      end else if (fall) begin
        dir <= is_down ? 18'sd65536 : 18'sd0;
      end else begin
        dir <= g[24] ? $signed(quot[17:0]) : -$signed(quot[17:0]);
      end
    end
    if (cmd.force_mul) begin
      pd <= 43'(dir) * 43'($signed({1'b0, gravity_scale}));
      ps <= 51'(d) * 51'($signed({1'b0, shake_scale}));
    end
    if (cmd.force_fin) begin
      frc <= $signed(sat_sm(f[51], f_rnd[39:0] | {39'd0, |f_rnd[51:40]}));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/imu_gravity_shake_estimator.sv -----
`default_nettype none

// Channel  Dir  Word                                        Handshake
// sample   in   accel_x/y/z, gyro_x/y/z, step_us            valid/ready
// result   out  force_x/y/z, rate_x/y/z, spin_accel_x/y/z,  valid/ready
//               free_fall
// cfg      in   cfg_index, cfg_data                         cfg_we
//
// One word in flight; with no stall, the gap between accepted words is
// set by the 24-step square root and two 40-step divisions per lane.
// sample.ready is high only while idle. The result sits in an output
// register, so a new word is taken while the last result waits.
// rst (synchronous) clears the filter state and loads register defaults.
module imu_gravity_shake_estimator #(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  igse_sample_if.sink          sample,
  igse_result_if.source        result
);

  igse_pkg::state_t    state, state_next;
  igse_pkg::lane_cmd_t cmd;

  logic [8:0]  axis_map;
  logic [15:0] lowpass_rate;
  logic [23:0] gravity_scale;
  logic [23:0] shake_scale;
  logic [15:0] freefall_threshold;

  igse_pkg::s16_t s_accel [3];
  igse_pkg::s16_t s_gyro [3];
  logic [19:0]    s_step;

  logic        primed;
  logic [37:0] xnum;
  logic [50:0] xlo;
  logic [50:0] xhi;
  logic [67:0] xsum;
  logic        xbig;
  logic [44:0] x;
  logic [47:0] sumsq;
  logic [23:0] mag;
  logic        fall;
  logic        out_valid;

  logic [16:0] k;
  logic        r_start, r_done;
  logic [23:0] root;

  logic [47:0]        lane_sq    [3];
  logic signed [16:0] lane_rate  [3];
  logic signed [31:0] lane_frc   [3];
  logic signed [31:0] lane_alpha [3];
  logic [2:0]         lane_done;

  logic out_free;
  assign out_free     = !out_valid || result.ready;
  assign sample.ready = (state == igse_pkg::ST_IDLE);
  assign result.valid = out_valid;

  assign xhi  = 51'(xnum[32:17]) * 51'(igse_pkg::X_RECIP);
  assign xsum = {xhi, 17'd0} + 68'(xlo);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_map           <= 9'd136;
      lowpass_rate       <= 16'd8042;
      gravity_scale      <= 24'd256;
      shake_scale        <= 24'd256;
      freefall_threshold <= 16'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        igse_pkg::CFG_AXIS_MAP:  axis_map           <= cfg_data[8:0];
        igse_pkg::CFG_LP_RATE:   lowpass_rate       <= cfg_data[15:0];
        igse_pkg::CFG_GRAV_SCL:  gravity_scale      <= cfg_data;
        igse_pkg::CFG_SHAKE_SCL: shake_scale        <= cfg_data;
        igse_pkg::CFG_FF_THRESH: freefall_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= igse_pkg::ST_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.upd_add) begin
        primed <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_accel[0] <= sample.accel_x;
      s_accel[1] <= sample.accel_y;
      s_accel[2] <= sample.accel_z;
      s_gyro[0]  <= sample.gyro_x;
      s_gyro[1]  <= sample.gyro_y;
      s_gyro[2]  <= sample.gyro_z;
      s_step     <= sample.step_us;
    end
    if (state == igse_pkg::ST_LOAD) begin
      xnum <= {36'(lowpass_rate) * 36'(s_step), 2'b00} + 38'(igse_pkg::X_RND);
    end
    if (state == igse_pkg::ST_XSTART) begin
      xlo  <= 51'(xnum[16:0]) * 51'(igse_pkg::X_RECIP);
      xbig <= (xnum >= 38'(igse_pkg::X_BIG));
    end
    if (state == igse_pkg::ST_XWAIT) begin
      x <= xbig ? 45'(igse_pkg::X_END_Q16) : 45'(xsum[65:47]);
    end
    if (state == igse_pkg::ST_SUM) begin
      sumsq <= 48'(50'(lane_sq[0]) + 50'(lane_sq[1]) + 50'(lane_sq[2]));
    end
    if (r_done) begin
      mag  <= root;
      fall <= !(root > {freefall_threshold, 8'd0});
    end
    if (cmd.commit) begin
      result.force_x      <= lane_frc[0];
      result.force_y      <= lane_frc[1];
      result.force_z      <= lane_frc[2];
      result.rate_x       <= lane_rate[0];
      result.rate_y       <= lane_rate[1];
      result.rate_z       <= lane_rate[2];
      result.spin_accel_x <= lane_alpha[0];
      result.spin_accel_y <= lane_alpha[1];
      result.spin_accel_z <= lane_alpha[2];
      result.free_fall    <= fall;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.primed = primed;
    r_start    = 1'b0;
    case (state)
      igse_pkg::ST_IDLE: begin
        if (sample.valid) begin
          state_next = igse_pkg::ST_LOAD;
        end
      end
      igse_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = igse_pkg::ST_XSTART;
      end
      igse_pkg::ST_XSTART: state_next = igse_pkg::ST_XWAIT;
      igse_pkg::ST_XWAIT:  state_next = igse_pkg::ST_COEF0;
      igse_pkg::ST_COEF0:  state_next = igse_pkg::ST_COEF1;
      igse_pkg::ST_COEF1:  state_next = igse_pkg::ST_COEF2;
      igse_pkg::ST_COEF2:  state_next = igse_pkg::ST_UMUL;
      igse_pkg::ST_UMUL: begin
        cmd.upd_mul = 1'b1;
        state_next  = igse_pkg::ST_UADD;
      end
      igse_pkg::ST_UADD: begin
        cmd.upd_add = 1'b1;
        state_next  = igse_pkg::ST_SQ;
      end
      igse_pkg::ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = igse_pkg::ST_SUM;
      end
      igse_pkg::ST_SUM: state_next = igse_pkg::ST_RSTART;
      igse_pkg::ST_RSTART: begin
        r_start    = 1'b1;
        state_next = igse_pkg::ST_RWAIT;
      end
      igse_pkg::ST_RWAIT: begin
        if (r_done) begin
          state_next = igse_pkg::ST_DSTART;
        end
      end
      igse_pkg::ST_DSTART: begin
        cmd.dir_start = 1'b1;
        state_next    = igse_pkg::ST_DWAIT;
      end
      igse_pkg::ST_DWAIT: begin
        if (lane_done[0]) begin
          state_next = igse_pkg::ST_ASTART;
        end
      end
      igse_pkg::ST_ASTART: begin
        cmd.alpha_start = 1'b1;
        state_next      = igse_pkg::ST_AWAIT;
      end
      igse_pkg::ST_AWAIT: begin
        if (lane_done[0]) begin
          state_next = igse_pkg::ST_FMUL;
        end
      end
      igse_pkg::ST_FMUL: begin
        cmd.force_mul = 1'b1;
        state_next    = igse_pkg::ST_FFIN;
      end
      igse_pkg::ST_FFIN: begin
        cmd.force_fin = 1'b1;
        state_next    = igse_pkg::ST_OUT;
      end
      igse_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = igse_pkg::ST_IDLE;
        end
      end
      default: state_next = igse_pkg::ST_IDLE;
    endcase
  end

  igse_coef #(.DEPTH(EXP_TABLE_DEPTH)) u_coef (
    .clk (clk),
    .x   (x),
    .k   (k)
  );

  igse_isqrt #(.W(48)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (r_start),
    .num   (sumsq),
    .done  (r_done),
    .root  (root)
  );

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane
    igse_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .map           (axis_map[3*gi +: 3]),
      .accel_src     (s_accel),
      .gyro_src      (s_gyro),
      .k             (k),
      .mag           (mag),
      .fall          (fall),
      .is_down       (gi == 1),
      .step          (s_step),
      .gravity_scale (gravity_scale),
      .shake_scale   (shake_scale),
      .square        (lane_sq[gi]),
      .rate          (lane_rate[gi]),
      .frc           (lane_frc[gi]),
      .alpha         (lane_alpha[gi]),
      .div_done      (lane_done[gi])
    );
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_GAP  = 250;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic [19:0]        us;
  } sample_t;

  typedef struct {
    longint force_v[3];
    longint rate_v[3];
    longint spin_v[3];
    bit     fall;
  } motion_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  igse_sample_if smp ();
  igse_result_if res ();

  imu_gravity_shake_estimator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(smp), .result(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and filter state
  longint unsigned map_r, lp_r, gscl_r, sscl_r, thr_r;
  longint est[3];
  longint prev_rate[3];
  bit     primed;

  sample_t feed_q[$];
  motion_t motion_q[$];
  sample_t cur;
  bit      took;
  bit      calm;
  int      gap, stall, idle_cycles, errs, n_words, n_settings;

  function automatic longint rdiv(longint a, longint d);
    if (a >= 0) return (a + d / 2) / d;
    return -((-a + d / 2) / d);
  endfunction

  function automatic longint fdiv(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint decay_q30(longint unsigned x);
    longint unsigned whole, frac, term;
    longint acc;
    whole = x >> 16;
    frac  = x & 64'hFFFF;
    term  = 64'd1 << 30;
    acc   = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * frac) >> 16) / k;
      acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    for (longint unsigned j = 0; j < whole; j++)
      acc = (acc * igse_pkg::EXP_M1_Q30 + (64'sd1 << 29)) / (64'sd1 << 30);
    return acc;
  endfunction

  function automatic longint knot(longint unsigned i);
    longint unsigned x;
    x = (i * igse_pkg::X_END_Q16 + 31) / 63;
    return 65536 - ((decay_q30(x) + 8192) / 16384);
  endfunction

  function automatic longint blend_q16(longint unsigned x);
    longint unsigned num, i, rem;
    longint t0, t1;
    if (x >= igse_pkg::X_END_Q16) return 65536;
    num = x * 63;
    i   = num / igse_pkg::X_END_Q16;
    rem = num % igse_pkg::X_END_Q16;
    t0  = knot(i);
    t1  = knot(i + 1);
    return t0 + fdiv((t1 - t0) * longint'(rem), igse_pkg::X_END_Q16);
  endfunction

  function automatic motion_t estimate(sample_t s);
    motion_t m;
    longint asrc[3], gsrc[3], acc[3], rt[3], dir[3];
    longint unsigned x, mag, sq, st;
    longint kq, a, g, sh, f;
    int sel;
    bit ng;
    asrc[0] = s.ax; asrc[1] = s.ay; asrc[2] = s.az;
    gsrc[0] = s.gx; gsrc[1] = s.gy; gsrc[2] = s.gz;
    st = s.us;
    for (int i = 0; i < 3; i++) begin
      sel = int'((map_r >> (3 * i)) & 3);
      ng  = map_r[3 * i + 2];
      a   = (sel < 3) ? asrc[sel] : 0;
      g   = (sel < 3) ? gsrc[sel] : 0;
      if (ng) begin
        a = -a;
        g = -g;
      end
      acc[i] = a * 256;
      rt[i]  = rdiv(g * igse_pkg::GYRO_TO_RATE_Q16, 65536);
    end
    if (!primed) begin
      for (int i = 0; i < 3; i++) est[i] = acc[i];
      primed = 1'b1;
    end else begin
      x  = (lp_r * st * 256 + igse_pkg::X_DIV_HALF) / igse_pkg::X_DIV_DEN;
      kq = blend_q16(x);
      for (int i = 0; i < 3; i++) est[i] = est[i] + fdiv(kq * (acc[i] - est[i]) + 32768, 65536);
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + longint'(est[i] * est[i]);
    mag    = root64(sq);
    m.fall = !(mag > thr_r * 256);
    for (int i = 0; i < 3; i++) begin
      if (m.fall) dir[i] = (i == 1) ? 65536 : 0;
      else dir[i] = rdiv(-est[i] * 65536, longint'(mag));
      sh = acc[i] - est[i];
      f  = dir[i] * longint'(gscl_r) - sh * longint'(sscl_r);
      m.force_v[i] = clip32(rdiv(f, 65536));
      m.rate_v[i]  = rt[i];
      m.spin_v[i]  = (st >= 2) ? clip32(rdiv((rt[i] - prev_rate[i]) * igse_pkg::ALPHA_SCALE,
                                             longint'(st)))
                               : 0;
      prev_rate[i] = rt[i];
    end
    return m;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    motion_t m;
    if (!rst) begin
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (smp.valid && smp.ready) begin
        motion_q.push_back(estimate(cur));
        took <= 1'b1;
        n_words++;
      end
      if (res.valid && res.ready) begin
        if (motion_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          m = motion_q.pop_front();
          check_field("force_x", m.force_v[0], longint'(res.force_x));
          check_field("force_y", m.force_v[1], longint'(res.force_y));
          check_field("force_z", m.force_v[2], longint'(res.force_z));
          check_field("rate_x", m.rate_v[0], longint'(res.rate_x));
          check_field("rate_y", m.rate_v[1], longint'(res.rate_y));
          check_field("rate_z", m.rate_v[2], longint'(res.rate_z));
          check_field("spin_accel_x", m.spin_v[0], longint'(res.spin_accel_x));
          check_field("spin_accel_y", m.spin_v[1], longint'(res.spin_accel_y));
          check_field("spin_accel_z", m.spin_v[2], longint'(res.spin_accel_z));
          check_field("free_fall", longint'(m.fall), longint'(res.free_fall));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (!rst && (!smp.valid || took)) begin
      took <= 1'b0;
      if (gap > 0) begin
        gap <= gap - 1;
        smp.valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        cur = feed_q.pop_front();
        smp.accel_x <= cur.ax;
        smp.accel_y <= cur.ay;
        smp.accel_z <= cur.az;
        smp.gyro_x  <= cur.gx;
        smp.gyro_y  <= cur.gy;
        smp.gyro_z  <= cur.gz;
        smp.step_us <= cur.us;
        smp.valid   <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 19);
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall > 0) begin
        stall <= stall - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) stall <= $urandom_range(1, 19);
      end
    end
  end

  task automatic push(int ax, int ay, int az, int gx, int gy, int gz, int us);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    s.us = 20'(us);
    feed_q.push_back(s);
  endtask

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = 24'(val);
    case (idx)
      igse_pkg::CFG_AXIS_MAP:  map_r  = val & 64'h1FF;
      igse_pkg::CFG_LP_RATE:   lp_r   = val & 64'hFFFF;
      igse_pkg::CFG_GRAV_SCL:  gscl_r = val & 64'hFFFFFF;
      igse_pkg::CFG_SHAKE_SCL: sscl_r = val & 64'hFFFFFF;
      igse_pkg::CFG_FF_THRESH: thr_r  = val & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (feed_q.size() > 0 || smp.valid || motion_q.size() > 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  function automatic int near_g();
    int v;
    v = $urandom_range(0, 3000);
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  task automatic random_word();
    int ax, ay, az, us, pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      ax = $urandom_range(0, 65535) - 32768;
      ay = $urandom_range(0, 65535) - 32768;
      az = $urandom_range(0, 65535) - 32768;
    end else if (pick < 5) begin
      ax = $urandom_range(0, 160) - 80;
      ay = $urandom_range(0, 160) - 80;
      az = $urandom_range(0, 160) - 80;
    end else begin
      ax = near_g(); ay = near_g(); az = near_g();
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) us = $urandom_range(0, 1);
    else if (pick < 4) us = $urandom_range(0, 1000000);
    else us = $urandom_range(2000, 10000);
    push(ax, ay, az, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
         $urandom_range(0, 65535) - 32768, us);
  endtask

  initial begin
    smp.valid = 1'b0;
    smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
    smp.gyro_x = '0; smp.gyro_y = '0; smp.gyro_z = '0;
    smp.step_us = '0;
    res.ready = 1'b0;
    took = 1'b0; calm = 1'b0; gap = 0; stall = 0;
    idle_cycles = 0; errs = 0; n_words = 0; n_settings = 1;
    map_r = 136; lp_r = 8042; gscl_r = 256; sscl_r = 256; thr_r = 128;
    primed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      est[i] = 0;
      prev_rate[i] = 0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: priming, extremes, short and long steps, free fall
    push(0, 0, 2509, 0, 0, 0, 4000);
    push(0, 0, 0, 0, 0, 0, 0);
    push(32767, 32767, 32767, 32767, 32767, 32767, 1);
    push(-32768, -32768, -32768, -32768, -32768, -32768, 2);
    push(32767, -32768, 0, -32768, 32767, 0, 1000000);
    push(-32768, 32767, -1, 32767, -32768, -1, 1000000);
    push(10, -10, 5, 1, -1, 0, 1000000);
    push(0, 0, 0, 0, 0, 0, 1000000);
    push(0, 2509, 0, 100, 200, 300, 3);
    push(0, 2509, 0, -100, -200, -300, 4000);
    push(21845, -21846, 10922, 21845, -21846, 10922, 699050);
    push(-21846, 21845, -10923, -21846, 21845, -10923, 349525);
    push(1, 1, 1, 1, 1, 1, 524288);
    push(-1, -1, -1, -1, -1, -1, 0);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(igse_pkg::CFG_AXIS_MAP, 0); write_reg(igse_pkg::CFG_LP_RATE, 0);
          write_reg(igse_pkg::CFG_GRAV_SCL, 0); write_reg(igse_pkg::CFG_SHAKE_SCL, 0);
          write_reg(igse_pkg::CFG_FF_THRESH, 0);
        end
        1: begin
          write_reg(igse_pkg::CFG_AXIS_MAP, 511); write_reg(igse_pkg::CFG_LP_RATE, 65535);
          write_reg(igse_pkg::CFG_GRAV_SCL, 24'hFFFFFF);
          write_reg(igse_pkg::CFG_SHAKE_SCL, 24'hFFFFFF);
          write_reg(igse_pkg::CFG_FF_THRESH, 65535);
        end
        2: begin
          write_reg(igse_pkg::CFG_AXIS_MAP, 9'b011_110_101);
          write_reg(igse_pkg::CFG_LP_RATE, 8042);
          write_reg(igse_pkg::CFG_GRAV_SCL, 24'h0FFFFF);
          write_reg(igse_pkg::CFG_SHAKE_SCL, 24'h000100);
          write_reg(igse_pkg::CFG_FF_THRESH, 128);
        end
        default: begin
          write_reg(igse_pkg::CFG_AXIS_MAP, $urandom_range(0, 511));
          write_reg(igse_pkg::CFG_LP_RATE, $urandom_range(0, 65535));
          write_reg(igse_pkg::CFG_GRAV_SCL, ($urandom_range(0, 1) == 1)
                                            ? $urandom_range(0, 24'hFFFFFF)
                                            : $urandom_range(0, 4096));
          write_reg(igse_pkg::CFG_SHAKE_SCL, ($urandom_range(0, 1) == 1)
                                             ? $urandom_range(0, 24'hFFFFFF)
                                             : $urandom_range(0, 4096));
          write_reg(igse_pkg::CFG_FF_THRESH, ($urandom_range(0, 3) == 0)
                                             ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 3000));
        end
      endcase
      n_settings++;
      if (p == 9) calm = 1'b1;
      repeat (64) random_word();
      drain();
    end

    $display("ran %0d sample words across %0d register settings", n_words, n_settings);
    $display("with extremes, free fall, short steps and random back-pressure");
    if (errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
